@@ rtl/core/igu_pkg.sv @@
// Shared types and constants for the int4 gate/up dot product unit.
// No dependencies; every other file in rtl/core imports this package.
package igu_pkg;

  localparam int LANES   = 8;   // nibbles per weight word
  localparam int ACT_W   = 16;  // Q4.12 activation
  localparam int WORD_W  = 32;  // packed weight word
  localparam int NIB_W   = 4;
  localparam int SCALE_W = 16;  // Q4.12 row scale
  localparam int RES_W   = 48;  // Q32.16 row result
  localparam int DOT_W   = 23;  // one word's dot product, signed
  localparam int Q_DEPTH = 2;   // front-to-back queue slots
  localparam int FRAC_DROP = 32; // Q.48 product down to Q32.16

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  localparam logic signed [NIB_W:0] NIB_BIAS = 5'sd8;

  typedef struct packed {
    logic [LANES-1:0][ACT_W-1:0] act;
    logic [WORD_W-1:0]           gate_word;
    logic [WORD_W-1:0]           up_word;
    logic signed [SCALE_W-1:0]   gate_scale;
    logic signed [SCALE_W-1:0]   up_scale;
    logic                        last;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SETUP,
    ST_MUL1,
    ST_MUL2,
    ST_SAT
  } bk_state_t;

endpackage

@@ rtl/core/igu_front.sv @@
// Front end: takes items, keeps the banked activation store, fetches eight lanes.
// Depends on igu_pkg; feeds igu_queue.
module igu_front #(
  parameter int MAX_HIDDEN = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [12:0]                         in_index,
  input  logic signed [15:0]                  in_act_value,
  input  logic [31:0]                         in_gate_word,
  input  logic [31:0]                         in_up_word,
  input  logic signed [15:0]                  in_gate_scale,
  input  logic signed [15:0]                  in_up_scale,
  input  logic                                in_last,
  output logic                                push,
  output igu_pkg::q_entry_t                   push_data,
  input  logic                                q_full
);
  import igu_pkg::*;

  localparam int BANK_DEPTH = (MAX_HIDDEN + LANES - 1) / LANES;
  localparam int BA_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [16:0] HIDDEN_LIM = 17'(MAX_HIDDEN);

  logic             accept;
  logic             ld_en;
  logic             wt_en;
  logic [15:0]      ld_row;
  logic [15:0]      wt_row;
  logic [BA_W-1:0]  ld_addr;
  logic [BA_W-1:0]  wt_addr;

  logic [LANES-1:0][ACT_W-1:0] rd_r;
  logic [LANES-1:0]            lane_ok_r;
  logic [LANES-1:0]            lane_ok_nxt;

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic [WORD_W-1:0]         s1_gate_r;
  logic [WORD_W-1:0]         s1_up_r;
  logic signed [SCALE_W-1:0] s1_gscale_r;
  logic signed [SCALE_W-1:0] s1_uscale_r;
  logic                      s1_last_r;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign ld_en    = accept && (in_op == OP_LOAD) && ({4'b0, in_index} < HIDDEN_LIM);
  assign wt_en    = accept && (in_op == OP_WEIGHT);

  // Lane k of bank k holds activation 8*row+k.
  assign ld_row  = {6'b0, in_index[12:3]};
  assign wt_row  = {3'b0, in_index};
  assign ld_addr = ld_row[BA_W-1:0];
  assign wt_addr = wt_row[BA_W-1:0];

  genvar k;
  generate
    for (k = 0; k < LANES; k++) begin : g_bank
      logic [ACT_W-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clk) begin
        if (ld_en && (in_index[2:0] == 3'(k))) begin
          mem[ld_addr] <= in_act_value;
        end
        if (wt_en) begin
          rd_r[k] <= mem[wt_addr];
        end
      end

      // Lanes past the end of the store read as zero.
      assign lane_ok_nxt[k] = {1'b0, in_index, 3'(k)} < HIDDEN_LIM;
    end
  endgenerate

  assign push = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (wt_en) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wt_en) begin
      lane_ok_r   <= lane_ok_nxt;
      s1_gate_r   <= in_gate_word;
      s1_up_r     <= in_up_word;
      s1_gscale_r <= in_gate_scale;
      s1_uscale_r <= in_up_scale;
      s1_last_r   <= in_last;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      push_data.act[i] = lane_ok_r[i] ? rd_r[i] : '0;
    end
    push_data.gate_word  = s1_gate_r;
    push_data.up_word    = s1_up_r;
    push_data.gate_scale = s1_gscale_r;
    push_data.up_scale   = s1_uscale_r;
    push_data.last       = s1_last_r;
  end

endmodule

@@ rtl/core/igu_queue.sv @@
// Short FIFO between the fetch front end and the arithmetic back end.
// Depends on igu_pkg for the entry type and depth.
module igu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  igu_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output igu_pkg::q_entry_t head,
  output logic              empty
);
  import igu_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/igu_back.sv @@
// Back end: word dot products, saturating row sums, shift-add product and rounding.
// Depends on igu_pkg; drains igu_queue and drives the result register.
module igu_back #(
  parameter int SUM_WIDTH = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  igu_pkg::q_entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [47:0] out_row_result
);
  import igu_pkg::*;

  localparam int PW = 2 * SUM_WIDTH + 32;
  localparam int BW = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
  localparam int QW = PW - FRAC_DROP;

  function automatic logic signed [DOT_W-1:0] word_dot(
    input logic [LANES-1:0][ACT_W-1:0] act,
    input logic [WORD_W-1:0]           word
  );
    logic signed [NIB_W:0]           w;
    logic signed [ACT_W+NIB_W:0]     p;
    logic signed [DOT_W-1:0]         acc;
    acc = '0;
    for (int k = 0; k < LANES; k++) begin
      w   = $signed({1'b0, word[NIB_W*k +: NIB_W]}) - NIB_BIAS;
      p   = $signed(act[k]) * w;
      acc = acc + {{(DOT_W - ACT_W - NIB_W - 1){p[ACT_W+NIB_W]}}, p};
    end
    return acc;
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [DOT_W-1:0]     d
  );
    logic signed [SUM_WIDTH:0] t;
    t = {s[SUM_WIDTH-1], s} + {{(SUM_WIDTH + 1 - DOT_W){d[DOT_W-1]}}, d};
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return t[SUM_WIDTH-1:0];
  endfunction

  bk_state_t state_r;
  bk_state_t state_nxt;

  logic acc_en;
  logic out_load;

  logic                      d_valid_r;
  logic                      d_valid_nxt;
  logic signed [DOT_W-1:0]   d_gdot_r;
  logic signed [DOT_W-1:0]   d_udot_r;
  logic                      d_last_r;
  logic signed [SCALE_W-1:0] d_gscale_r;
  logic signed [SCALE_W-1:0] d_uscale_r;

  logic signed [SUM_WIDTH-1:0] gsum_r;
  logic signed [SUM_WIDTH-1:0] gsum_nxt;
  logic signed [SUM_WIDTH-1:0] usum_r;
  logic signed [SUM_WIDTH-1:0] usum_nxt;

  logic                 neg_r;
  logic                 neg_nxt;
  logic [SUM_WIDTH-1:0] umag_r;
  logic [SUM_WIDTH-1:0] umag_nxt;
  logic [PW-1:0]        a_r;
  logic [PW-1:0]        a_nxt;
  logic [BW-1:0]        b_r;
  logic [BW-1:0]        b_nxt;
  logic [PW-1:0]        acc_r;
  logic [PW-1:0]        acc_nxt;

  logic [SUM_WIDTH-1:0] gmag;
  logic [SCALE_W-1:0]   gsmag;
  logic [SCALE_W-1:0]   usmag;
  logic [31:0]          smul;

  logic [QW-1:0]         q;
  logic [QW:0]           qn;
  logic                  frac_nz;
  logic signed [RES_W-1:0] res;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [RES_W-1:0] out_result_r;

  // Control outputs
  always_comb begin
    pop      = (state_r == ST_ACC) && !empty && !(d_valid_r && d_last_r);
    acc_en   = (state_r == ST_ACC) && d_valid_r;
    out_load = (state_r == ST_SAT) && (!out_valid_r || !out_stall);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC:   if (acc_en && d_last_r) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_MUL1;
      ST_MUL1:  if (b_r == '0) state_nxt = ST_MUL2;
      ST_MUL2:  if (b_r == '0) state_nxt = ST_SAT;
      ST_SAT:   if (out_load) state_nxt = ST_ACC;
      default:  state_nxt = ST_ACC;
    endcase
  end

  assign gmag  = gsum_r[SUM_WIDTH-1] ? (~gsum_r + 1'b1) : gsum_r;
  assign gsmag = d_gscale_r[SCALE_W-1] ? (~d_gscale_r + 1'b1) : d_gscale_r;
  assign usmag = d_uscale_r[SCALE_W-1] ? (~d_uscale_r + 1'b1) : d_uscale_r;
  assign smul  = gsmag * usmag;

  // Floor of the signed Q.48 product to Q.16, then clamp to 48-bit Q32.16.
  always_comb begin
    q       = acc_r[PW-1:FRAC_DROP];
    frac_nz = |acc_r[FRAC_DROP-1:0];
    qn      = {1'b0, q} + (QW + 1)'(frac_nz);
    if (!neg_r) begin
      if (|q[QW-1:RES_W-1]) begin
        res = {1'b0, {(RES_W-1){1'b1}}};
      end else begin
        res = q[RES_W-1:0];
      end
    end else begin
      if ((|qn[QW:RES_W]) || (qn[RES_W-1] && (|qn[RES_W-2:0]))) begin
        res = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
        res = -qn[RES_W-1:0];
      end
    end
  end

  // Datapath next values
  always_comb begin
    d_valid_nxt   = d_valid_r;
    gsum_nxt      = gsum_r;
    usum_nxt      = usum_r;
    neg_nxt       = neg_r;
    umag_nxt      = umag_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;

    if (pop) begin
      d_valid_nxt = 1'b1;
    end else if (acc_en) begin
      d_valid_nxt = 1'b0;
    end

    if (acc_en) begin
      gsum_nxt = sat_add(gsum_r, d_gdot_r);
      usum_nxt = sat_add(usum_r, d_udot_r);
    end

    case (state_r)
      ST_SETUP: begin
        // Latch magnitudes and sign, clear the row sums.
        neg_nxt  = gsum_r[SUM_WIDTH-1] ^ usum_r[SUM_WIDTH-1]
                 ^ d_gscale_r[SCALE_W-1] ^ d_uscale_r[SCALE_W-1];
        umag_nxt = usum_r[SUM_WIDTH-1] ? (~usum_r + 1'b1) : usum_r;
        a_nxt    = PW'(gmag);
        b_nxt    = BW'(smul);
        acc_nxt  = '0;
        gsum_nxt = '0;
        usum_nxt = '0;
      end
      ST_MUL1: begin
        if (b_r == '0) begin
          // Gate part done: multiply it by the up magnitude next.
          a_nxt   = acc_r;
          b_nxt   = BW'(umag_r);
          acc_nxt = '0;
        end else begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = a_r << 1;
          b_nxt = b_r >> 1;
        end
      end
      ST_MUL2: begin
        if (b_r != '0) begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = a_r << 1;
          b_nxt = b_r >> 1;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      d_valid_r   <= 1'b0;
      gsum_r      <= '0;
      usum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      d_valid_r   <= d_valid_nxt;
      gsum_r      <= gsum_nxt;
      usum_r      <= usum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      d_gdot_r   <= word_dot(head.act, head.gate_word);
      d_udot_r   <= word_dot(head.act, head.up_word);
      d_last_r   <= head.last;
      d_gscale_r <= head.gate_scale;
      d_uscale_r <= head.up_scale;
    end
    neg_r  <= neg_nxt;
    umag_r <= umag_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    if (out_load) begin
      out_result_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_result = out_result_r;

endmodule

@@ rtl/core/int4_gate_up_dot_product_unit.sv @@
// Top level of the int4 gate/up dot product unit.
// Depends on igu_pkg, igu_front, igu_queue and igu_back.
//
// Load items (op 0) write one Q4.12 activation into a store of MAX_HIDDEN
// entries, split into eight banks so that a weight item (op 1) fetches the
// eight activations of its word index in parallel. Each weight item carries
// a gate word and an up word of eight int4 weights (nibble minus 8); their
// dot products against the fetched lanes are added, saturating, into two
// SUM_WIDTH-bit row sums. A weight item with last set yields one Q32.16
// result, gate_sum*gate_scale*up_sum*up_scale floored and clamped to 48 bits,
// and clears both sums. Loads and ordinary weight items go at one item per
// cycle while in_stall is low: the front end does the bank read, a two-slot
// queue decouples it from the back end, which forms the dot products and
// updates the sums in a one-stage pipe. A last item holds the back end in a
// shared shift-add multiplier, through a setup state, the gate and up
// multiply states and a saturate state; items keep entering until the queue
// is full and the front end holds a fetched item. Entries of the store that
// were never loaded read back undefined; there is no clearing pass after
// reset. The result register decouples out_stall from the input side.
module int4_gate_up_dot_product_unit #(
  parameter int MAX_HIDDEN = 8192,
  parameter int SUM_WIDTH  = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [12:0]        in_index,
  input  logic signed [15:0] in_act_value,
  input  logic [31:0]        in_gate_word,
  input  logic [31:0]        in_up_word,
  input  logic signed [15:0] in_gate_scale,
  input  logic signed [15:0] in_up_scale,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_row_result
);
  import igu_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_wdata;
  q_entry_t q_head;

  // Accept items, write loads, fetch eight lanes for weight words.
  igu_front #(
    .MAX_HIDDEN (MAX_HIDDEN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_act_value  (in_act_value),
    .in_gate_word  (in_gate_word),
    .in_up_word    (in_up_word),
    .in_gate_scale (in_gate_scale),
    .in_up_scale   (in_up_scale),
    .in_last       (in_last),
    .push          (q_push),
    .push_data     (q_wdata),
    .q_full        (q_full)
  );

  // Hold fetched weight items while the back end multiplies.
  igu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Accumulate, multiply, round and drive the result register.
  igu_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_result (out_row_result)
  );

endmodule

@@ sim/tb_int4_gate_up_dot_product_unit.sv @@
// Self-checking testbench for int4_gate_up_dot_product_unit: activation loads,
// gate/up weight rows and checked Q32.16 row results under random flow control.
// Depends on igu_pkg and the RTL of the unit; nothing else.
`timescale 1ns / 100ps

module tb_int4_gate_up_dot_product_unit;
  import igu_pkg::*;

  localparam int MAX_HIDDEN  = 8192;
  localparam int SUM_W       = 40;
  localparam int ACT_WORDS   = MAX_HIDDEN / LANES;  // words backed by the store
  localparam int RANDOM_ITEMS = 1750;
  // Long enough that the row result clamps to 48 bits: the biggest word adds 2^21.
  localparam int SAT_ROW_LEN = 256;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 150;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic               op;
    logic [12:0]        index;
    logic signed [15:0] act;
    logic [31:0]        gate_word;
    logic [31:0]        up_word;
    logic signed [15:0] gate_scale;
    logic signed [15:0] up_scale;
    logic               last;
  } gu_item_t;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_LOAD;
  logic [12:0]        in_index = '0;
  logic signed [15:0] in_act_value = '0;
  logic [31:0]        in_gate_word = '0;
  logic [31:0]        in_up_word = '0;
  logic signed [15:0] in_gate_scale = '0;
  logic signed [15:0] in_up_scale = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] out_row_result;

  int4_gate_up_dot_product_unit #(
    .MAX_HIDDEN(MAX_HIDDEN),
    .SUM_WIDTH (SUM_W)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_act_value  (in_act_value),
    .in_gate_word  (in_gate_word),
    .in_up_word    (in_up_word),
    .in_gate_scale (in_gate_scale),
    .in_up_scale   (in_up_scale),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_result(out_row_result)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the activation store and of both row sums,
  // advanced once per accepted item, in acceptance order.
  // ---------------------------------------------------------------------------
  logic signed [15:0] act_shadow [0:MAX_HIDDEN-1];
  longint             gate_acc;
  longint             up_acc;
  logic signed [47:0] row_results_due [$];

  int  loads_seen;
  int  weights_seen;
  int  results_checked;
  int  fail_count;
  longint cycle_count;

  // One word's contribution: nibble k (minus the bias) times activation 8*widx+k.
  // Lanes past the end of the store read as zero and add nothing.
  function automatic longint word_dot(logic [31:0] word, logic [12:0] widx);
    longint acc;
    int     ai;
    int     nib;
    acc = 0;
    for (int k = 0; k < LANES; k++) begin
      ai  = int'(widx) * LANES + k;
      nib = int'(word[NIB_W*k +: NIB_W]);
      if (ai < MAX_HIDDEN)
        acc += longint'(act_shadow[ai]) * longint'(nib - int'(NIB_BIAS));
    end
    return acc;
  endfunction

  // Add with clamping to the signed SUM_W-bit range.
  function automatic longint sum_sat_add(longint s, longint d);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    lo = -hi - 1;
    if (d > 0 && s > hi - d) return hi;
    if (d < 0 && s < lo - d) return lo;
    return s + d;
  endfunction

  // Exact four-factor product in Q.48, floored down to Q32.16, clamped to 48 bits.
  // The exact product needs at most 110 bits, so 112 holds it without loss.
  function automatic logic signed [47:0] row_product(longint g, longint gs,
                                                     longint u, longint us);
    logic signed [111:0] fg, fgs, fu, fus, prod, floored, hi, lo;
    fg  = g;
    fgs = gs;
    fu  = u;
    fus = us;
    hi  = (112'sd1 <<< (RES_W - 1)) - 112'sd1;
    lo  = -hi - 112'sd1;
    prod    = fg * fgs * fu * fus;
    floored = prod >>> FRAC_DROP;
    if (floored > hi) floored = hi;
    if (floored < lo) floored = lo;
    return floored[RES_W-1:0];
  endfunction

  task automatic apply_item(input gu_item_t it);
    if (it.op == OP_LOAD) begin
      // Last is ignored on loads.
      if (it.index < MAX_HIDDEN) act_shadow[it.index] = it.act;
      loads_seen++;
    end else begin
      gate_acc = sum_sat_add(gate_acc, word_dot(it.gate_word, it.index));
      up_acc   = sum_sat_add(up_acc, word_dot(it.up_word, it.index));
      weights_seen++;
      if (it.last) begin
        row_results_due.push_back(row_product(gate_acc, it.gate_scale,
                                              up_acc, it.up_scale));
        gate_acc = 0;
        up_acc   = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take items from the pending queue, offer them in bursts with random
  // gaps, hold each one until the unit accepts it.
  // ---------------------------------------------------------------------------
  gu_item_t pending_items [$];
  gu_item_t cur_item;
  bit       item_taken;
  bit       sender_steady;
  int       burst_left;
  int       gap_left;
  int       items_queued;
  int       items_accepted;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      apply_item(cur_item);
      item_taken = 1'b1;
      items_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        in_op         <= cur_item.op;
        in_index      <= cur_item.index;
        in_act_value  <= cur_item.act;
        in_gate_word  <= cur_item.gate_word;
        in_up_word    <= cur_item.up_word;
        in_gate_scale <= cur_item.gate_scale;
        in_up_scale   <= cur_item.up_scale;
        in_last       <= cur_item.last;
        in_valid      <= 1'b1;
        // Close the burst and pick the next gap; gap zero chains bursts.
        if (burst_left > 0) begin
          burst_left--;
        end else if (!sender_steady) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern that is picked anew at random, plus one
  // long hold-off that lets the unit fill up and push back on its input.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_FREE;
  int       mode_left;
  int       hold_left;
  bit       long_hold_go;
  bit       long_hold_done;

  always @(negedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted row result with the oldest one due.
  // ---------------------------------------------------------------------------
  logic signed [47:0] row_expected;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (row_results_due.size() == 0) begin
        $error("row_result: expected none, got %0d", out_row_result);
        fail_count++;
      end else begin
        row_expected = row_results_due.pop_front();
        results_checked++;
        if (out_row_result !== row_expected) begin
          $error("row_result: expected %0d, got %0d", row_expected, out_row_result);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Track which store entries are written so that no
  // weight item ever reads an entry that was never loaded.
  // ---------------------------------------------------------------------------
  bit act_written [0:MAX_HIDDEN-1];
  bit word_listed [0:ACT_WORDS-1];
  int ready_words [$];

  function automatic logic signed [15:0] pick_q412();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8888_8888;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_load(input int idx, input logic signed [15:0] val,
                            input logic lst);
    gu_item_t it;
    int       w;
    it.op         = OP_LOAD;
    it.index      = 13'(idx);
    it.act        = val;
    it.gate_word  = $urandom;
    it.up_word    = $urandom;
    it.gate_scale = 16'($urandom);
    it.up_scale   = 16'($urandom);
    it.last       = lst;
    pending_items.push_back(it);
    items_queued++;
    act_written[idx] = 1'b1;
    w = idx / LANES;
    if (!word_listed[w]) begin
      word_listed[w] = 1'b1;
      for (int k = 0; k < LANES; k++)
        if (!act_written[w*LANES + k]) word_listed[w] = 1'b0;
      if (word_listed[w]) ready_words.push_back(w);
    end
  endtask

  task automatic queue_weight(input int idx, input logic [31:0] gw,
                              input logic [31:0] uw, input logic signed [15:0] gs,
                              input logic signed [15:0] us, input logic lst);
    gu_item_t it;
    it.op         = OP_WEIGHT;
    it.index      = 13'(idx);
    it.act        = 16'($urandom);
    it.gate_word  = gw;
    it.up_word    = uw;
    it.gate_scale = gs;
    it.up_scale   = us;
    it.last       = lst;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Hold the sender until every queued item is in and every result is out.
  task automatic wait_idle();
    while (items_accepted != items_queued || row_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int rand_target;
    int pick;
    int len;
    int w;
    int idx;

    gate_acc = 0;
    up_acc   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: activation extremes in word 0, the top store entry with last
    // set on a load, zero weights, words past the store, scale extremes, a
    // small product from one-LSB scales of opposite sign, and a zero scale.
    queue_load(0, 16'sh8000, 1'b0);
    queue_load(1, 16'sh7fff, 1'b0);
    queue_load(2, 16'sh0000, 1'b0);
    queue_load(3, 16'sh0001, 1'b0);
    queue_load(4, -16'sd1, 1'b0);
    queue_load(5, 16'sd4096, 1'b0);
    queue_load(6, -16'sd4096, 1'b0);
    queue_load(7, 16'sd12345, 1'b1);
    queue_load(MAX_HIDDEN - 1, 16'sh7fff, 1'b1);
    queue_weight(0, 32'h0000_0000, 32'hffff_ffff, 16'sh0000, 16'sh0000, 1'b0);
    queue_weight(0, 32'h8888_8888, 32'h0f0f_0f0f, 16'sh8000, 16'sh7fff, 1'b1);
    queue_weight(8191, $urandom, $urandom, 16'sh8000, 16'sh8000, 1'b1);
    queue_weight(ACT_WORDS, 32'hffff_ffff, 32'hffff_ffff, 16'sh0000, 16'sh0000, 1'b0);
    queue_weight(0, 32'hffff_ffff, 32'h0000_0000, 16'sh7fff, 16'sh7fff, 1'b1);
    queue_weight(0, 32'h1234_5678, 32'h9abc_def0, 16'sh0001, -16'sd1, 1'b1);
    queue_weight(0, 32'h0123_4567, 32'h89ab_cdef, 16'sh8000, 16'sh8000, 1'b1);
    queue_weight(0, 32'h0000_0000, 32'h0000_0000, 16'sh0000, 16'sh7fff, 1'b1);
    wait_idle();

    // Long row: push gate_sum far up and up_sum far down, then step both back
    // on the last word so the result clamps. Offer it back to back.
    sender_steady = 1'b1;
    for (int k = 0; k < LANES; k++) queue_load(LANES + k, 16'sh8000, 1'b0);
    for (int n = 0; n < SAT_ROW_LEN; n++)
      queue_weight(1, 32'h0000_0000, 32'hffff_ffff, pick_q412(), pick_q412(), 1'b0);
    queue_weight(1, 32'hffff_ffff, 32'h0000_0000, 16'sh8000, 16'sh7fff, 1'b1);
    wait_idle();
    sender_steady = 1'b0;

    // Random: mostly well-formed rows over loaded words, with word fills,
    // scattered loads and loads dropped into the middle of rows as noise.
    long_hold_go = 1'b1;
    rand_target  = items_queued + RANDOM_ITEMS;
    while (items_queued < rand_target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        w = $urandom_range(0, ACT_WORDS - 1);
        for (int k = 0; k < LANES; k++)
          queue_load(w*LANES + k, pick_q412(), $urandom_range(0, 1));
      end else if (pick < 25) begin
        len = $urandom_range(1, 6);
        for (int n = 0; n < len; n++)
          queue_load($urandom_range(0, MAX_HIDDEN - 1), pick_q412(), $urandom_range(0, 1));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int n = 0; n < len; n++) begin
          if ($urandom_range(0, 9) == 0)
            idx = $urandom_range(ACT_WORDS, 8191);
          else
            idx = ready_words[$urandom_range(0, ready_words.size() - 1)];
          queue_weight(idx, pick_word(), pick_word(), pick_q412(), pick_q412(),
                       n == len - 1);
          // Noise: a stray load inside the row; its word may not be full yet.
          if (pick >= 95 && n != len - 1)
            queue_load($urandom_range(0, MAX_HIDDEN - 1), pick_q412(), 1'b1);
        end
      end
    end
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads and %0d weight words, %0d row results compared",
             loads_seen, weights_seen, results_checked);
    $display("included a %0d-word back-to-back row whose result clamps, and a long output hold-off",
             SAT_ROW_LEN + 1);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
